>>> hw/rtl/vmalu_pkg.sv
package vmalu_pkg;

  typedef enum logic [3:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_NEG = 4'd4,
    CMD_INC = 4'd5,
    CMD_DEC = 4'd6,
    CMD_NOT = 4'd7,
    CMD_AND = 4'd8,
    CMD_OR  = 4'd9,
    CMD_XOR = 4'd10,
    CMD_SHL = 4'd11,
    CMD_SAR = 4'd12
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_DIV_ZERO    = 2'd1,
    ERR_SHIFT_RANGE = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0,
    KIND_MUL    = 2'd1,
    KIND_DIV    = 2'd2
  } kind_t;

  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int DIV_STEPS = 64;
  localparam logic [63:0] MAX_SHIFT = 64'd63;

  // One classified word as it waits between the front and the back.
  typedef struct packed {
    kind_t       kind;
    err_t        err;
    logic [63:0] a;
    logic [63:0] b;
  } qword_t;

  typedef struct packed {
    logic   push;
    qword_t word;
  } qpush_t;

  typedef struct packed {
    kind_t       kind;
    err_t        err;
    logic        neg;
    logic [63:0] val;
    logic [63:0] rem;
    logic [63:0] dvs;
  } stage_t;

endpackage

>>> hw/rtl/vmalu_front.sv
module vmalu_front import vmalu_pkg::*; (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         command,
  input  logic signed [63:0] left_operand,
  input  logic signed [63:0] right_operand,
  input  logic               q_full,
  output qpush_t             qp
);

  logic [63:0] a;
  logic [63:0] b;
  qword_t      w;

  assign a = left_operand;
  assign b = right_operand;
  assign in_stall = q_full;

  // Simple operations finish here; multiply and divide are passed on with their operands.
  always_comb begin
    w.kind = KIND_SIMPLE;
    w.err  = ERR_NONE;
    w.a    = '0;
    w.b    = b;
    unique case (command) inside
      CMD_ADD: w.a = a + b;
      CMD_SUB: w.a = a - b;
      CMD_MUL: begin
        w.kind = KIND_MUL;
        w.a    = a;
      end
      CMD_DIV: begin
        w.kind = KIND_DIV;
        w.a    = a;
        if (b == '0) w.err = ERR_DIV_ZERO;
      end
      CMD_NEG: w.a = '0 - a;
      CMD_INC: w.a = a + 64'd1;
      CMD_DEC: w.a = a - 64'd1;
      CMD_NOT: w.a = ~a;
      CMD_AND: w.a = a & b;
      CMD_OR:  w.a = a | b;
      CMD_XOR: w.a = a ^ b;
      CMD_SHL, CMD_SAR: begin
        if (b > MAX_SHIFT) begin
          w.err = ERR_SHIFT_RANGE;
        end else if (command == CMD_SHL) begin
          w.a = a << b[5:0];
        end else begin
          w.a = $unsigned(left_operand >>> b[5:0]);
        end
      end
      default: w.a = '0;
    endcase
  end

  assign qp.push = in_valid && !q_full;
  assign qp.word = w;

endmodule

>>> hw/rtl/vmalu_queue.sv
module vmalu_queue import vmalu_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  qpush_t qp,
  output logic   q_full,
  input  logic   pop,
  output logic   q_valid,
  output qword_t q_word
);

  qword_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_pop;

  assign q_full  = (count == (QPTR_W+1)'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_word  = mem[rd_ptr];
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (qp.push) mem[wr_ptr] <= qp.word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (qp.push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (qp.push && !do_pop)      count <= count + (QPTR_W+1)'(1);
      else if (!qp.push && do_pop) count <= count - (QPTR_W+1)'(1);
    end
  end

endmodule

>>> hw/rtl/vmalu_back.sv
module vmalu_back import vmalu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  qword_t             q_word,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] result_value,
  output logic [1:0]         error_code
);

  stage_t              pipe [DIV_STEPS+1];
  logic [DIV_STEPS:0]  vld;
  logic                adv;
  stage_t              prep;
  stage_t              last;
  logic [63:0]         fin_val;
  logic [63:0]         mid_sum;

  function automatic logic [63:0] mag(input logic [63:0] v);
    mag = v[63] ? ('0 - v) : v;
  endfunction

  // One restoring step: the quotient bits enter val from the right as the dividend leaves it.
  function automatic stage_t div_step(input stage_t s);
    stage_t      r;
    logic [63:0] sh;
    logic        ge;
    r  = s;
    sh = {s.rem[62:0], s.val[63]};
    ge = (sh >= s.dvs);
    if (s.kind == KIND_DIV) begin
      r.rem = ge ? (sh - s.dvs) : sh;
      r.val = {s.val[62:0], ge};
    end
    return r;
  endfunction

  assign adv = !out_valid || !out_stall;
  assign pop = adv;

  always_comb begin
    prep.kind = q_word.kind;
    prep.err  = q_word.err;
    prep.neg  = q_word.a[63] ^ q_word.b[63];
    prep.val  = q_word.a;
    prep.rem  = '0;
    prep.dvs  = '0;
    unique case (q_word.kind)
      KIND_MUL: begin
        prep.val = 64'(q_word.a[31:0]) * 64'(q_word.b[31:0]);
        prep.rem = 64'(q_word.a[31:0]) * 64'(q_word.b[63:32]);
        prep.dvs = 64'(q_word.a[63:32]) * 64'(q_word.b[31:0]);
      end
      KIND_DIV: begin
        prep.val = mag(q_word.a);
        prep.dvs = mag(q_word.b);
      end
      default: prep.val = q_word.a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe[0] <= prep;
      for (int i = 1; i <= DIV_STEPS; i++) pipe[i] <= div_step(pipe[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DIV_STEPS-1:0], q_valid};
    end
  end

  assign last    = pipe[DIV_STEPS];
  assign mid_sum = last.rem + last.dvs;

  always_comb begin
    unique case (last.kind)
      KIND_MUL: fin_val = last.val + {mid_sum[31:0], 32'd0};
      KIND_DIV: fin_val = last.neg ? ('0 - last.val) : last.val;
      default:  fin_val = last.val;
    endcase
    if (last.err != ERR_NONE) fin_val = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_value <= $signed(fin_val);
      error_code   <= last.err;
    end
  end

endmodule

>>> hw/rtl/vm_int64_alu.sv
// 64-bit signed integer ALU. One word is accepted per cycle while the queue is
// not full, and results leave in order, one per cycle while the output is not
// stalled. Every operation passes through the divider, a pipeline of 64
// restoring steps, so that order is kept. Multiply uses three 32-bit partial
// products in the first back stage. A four-word queue separates the accepting
// front from the execution pipeline, so a stalled output holds the pipeline
// while the front still fills the queue. Errors give a zero result.
module vm_int64_alu import vmalu_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         command,
  input  logic signed [63:0] left_operand,
  input  logic signed [63:0] right_operand,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] result_value,
  output logic [1:0]         error_code
);

  qpush_t qp;
  logic   q_full;
  logic   q_valid;
  logic   pop;
  qword_t q_word;

  vmalu_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .left_operand  (left_operand),
    .right_operand (right_operand),
    .q_full        (q_full),
    .qp            (qp)
  );

  vmalu_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .qp      (qp),
    .q_full  (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .q_word  (q_word)
  );

  vmalu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_word       (q_word),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .error_code   (error_code)
  );

endmodule

>>> dv/tb_vm_int64_alu.sv
`timescale 1ns / 100ps

class alu_scoreboard;
  logic [63:0] want_val[$];
  logic [1:0]  want_err[$];
  int          errors;

  function new();
    errors = 0;
  endfunction

  // Works out the result of one accepted word and queues it.
  function void note_word(logic [3:0] cmd, logic [63:0] a, logic [63:0] b);
    logic [63:0] v;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [1:0]  e;
    v = 64'd0;
    e = vmalu_pkg::ERR_NONE;
    case (cmd)
      vmalu_pkg::CMD_ADD: v = a + b;
      vmalu_pkg::CMD_SUB: v = a - b;
      vmalu_pkg::CMD_MUL: v = a * b;
      vmalu_pkg::CMD_DIV: begin
        if (b == 64'd0) begin
          e = vmalu_pkg::ERR_DIV_ZERO;
        end else if (a == 64'h8000000000000000 && b == '1) begin
          v = a;
        end else begin
          ma = a[63] ? -a : a;
          mb = b[63] ? -b : b;
          v = ma / mb;
          if (a[63] ^ b[63]) v = -v;
        end
      end
      vmalu_pkg::CMD_NEG: v = -a;
      vmalu_pkg::CMD_INC: v = a + 64'd1;
      vmalu_pkg::CMD_DEC: v = a - 64'd1;
      vmalu_pkg::CMD_NOT: v = ~a;
      vmalu_pkg::CMD_AND: v = a & b;
      vmalu_pkg::CMD_OR:  v = a | b;
      vmalu_pkg::CMD_XOR: v = a ^ b;
      vmalu_pkg::CMD_SHL, vmalu_pkg::CMD_SAR: begin
        if (b > vmalu_pkg::MAX_SHIFT) begin
          e = vmalu_pkg::ERR_SHIFT_RANGE;
        end else if (cmd == vmalu_pkg::CMD_SHL) begin
          v = a << b[5:0];
        end else begin
          v = $signed(a) >>> b[5:0];
        end
      end
      default: v = 64'd0;
    endcase
    want_val = {want_val, v};
    want_err = {want_err, e};
  endfunction

  function void check_result(logic [63:0] v, logic [1:0] e);
    logic [63:0] xv;
    logic [1:0]  xe;
    if (want_val.size() == 0) begin
      $display("%0t: result with nothing expected: value %h error %0d", $time, v, e);
      errors++;
      return;
    end
    xv = want_val.pop_front();
    xe = want_err.pop_front();
    if (v !== xv) begin
      $display("%0t: result_value expected %h actual %h", $time, xv, v);
      errors++;
    end
    if (e !== xe) begin
      $display("%0t: error_code expected %0d actual %0d", $time, xe, e);
      errors++;
    end
  endfunction
endclass

module tb_vm_int64_alu;
  import vmalu_pkg::*;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [3:0]         command;
  logic signed [63:0] left_operand;
  logic signed [63:0] right_operand;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [63:0] result_value;
  logic [1:0]         error_code;

  alu_scoreboard sb;
  int  send_idle;
  int  recv_stall;
  int  hold_off   = 0;
  bit  hold_req   = 1'b0;
  bit  hold_taken = 1'b0;
  int  cycles     = 0;

  localparam logic [63:0] MIN64 = 64'h8000000000000000;
  localparam logic [63:0] MAX64 = 64'h7FFFFFFFFFFFFFFF;

  vm_int64_alu uut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Operand with bias towards the awkward values.
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return MIN64;
      1: return MAX64;
      2: return 64'd0;
      3: return '1;
      4: return 64'($urandom_range(0, 70));
      5: return -64'($urandom_range(1, 70));
      6: return 64'($urandom);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(logic [3:0] cmd, logic [63:0] a, logic [63:0] b);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    left_operand  <= a;
    right_operand <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(cmd, a, b);
    @(negedge clk);
  endtask

  task automatic run_phase(int n);
    logic [63:0] b;
    logic [3:0]  c;
    repeat (n) begin
      c = 4'($urandom_range(0, 15));
      b = pick_operand();
      // Mostly in-range shift counts so both shifts do real work.
      if ((c == CMD_SHL || c == CMD_SAR) && $urandom_range(0, 3) != 0)
        b = 64'($urandom_range(0, 63));
      send_word(c, pick_operand(), b);
    end
  endtask

  // Receiver side: random stalls plus one long hold-off when asked for.
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_off   <= 300;
      out_stall  <= 1'b1;
    end else if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off  <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(result_value, error_code);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb_vm_int64_alu: errors");
      $finish;
    end
  end

  initial begin
    sb            = new();
    send_idle     = 0;
    recv_stall    = 0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    command       = 4'd0;
    left_operand  = '0;
    right_operand = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_word(CMD_ADD, MAX64, 64'd1);
    send_word(CMD_SUB, MIN64, 64'd1);
    send_word(CMD_MUL, MAX64, MAX64);
    send_word(CMD_MUL, MIN64, '1);
    send_word(CMD_DIV, 64'd7, 64'd0);
    send_word(CMD_DIV, MIN64, '1);
    send_word(CMD_DIV, -64'd7, 64'd2);
    send_word(CMD_DIV, 64'd7, -64'd2);
    send_word(CMD_DIV, MIN64, MIN64);
    send_word(CMD_NEG, MIN64, '1);
    send_word(CMD_INC, MAX64, 64'd0);
    send_word(CMD_DEC, MIN64, MAX64);
    send_word(CMD_NOT, 64'd0, MIN64);
    send_word(CMD_AND, '1, 64'h5555AAAA5555AAAA);
    send_word(CMD_OR, MIN64, 64'd1);
    send_word(CMD_XOR, '1, MAX64);
    send_word(CMD_SHL, '1, 64'd63);
    send_word(CMD_SHL, 64'd1, 64'd64);
    send_word(CMD_SHL, 64'd1, '1);
    send_word(CMD_SAR, MIN64, 64'd63);
    send_word(CMD_SAR, MIN64, 64'd0);
    send_word(CMD_SAR, MIN64, MIN64);
    send_word(4'd13, '1, '1);
    send_word(4'd15, MAX64, MIN64);

    run_phase(200);
    send_idle = 50;
    run_phase(200);
    send_idle  = 0;
    recv_stall = 50;
    run_phase(200);
    send_idle  = 29;
    recv_stall = 29;
    run_phase(150);
    // Long hold-off while the sender keeps offering words, to fill the block.
    send_idle  = 0;
    recv_stall = 0;
    hold_req   = 1'b1;
    run_phase(150);
    in_valid <= 1'b0;

    while (sb.want_val.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_vm_int64_alu: clean");
    end else begin
      $display("tb_vm_int64_alu: errors");
    end
    $finish;
  end
endmodule

>>> vm_int64_alu.f
hw/rtl/vmalu_pkg.sv
hw/rtl/vmalu_front.sv
hw/rtl/vmalu_queue.sv
hw/rtl/vmalu_back.sv
hw/rtl/vm_int64_alu.sv
dv/tb_vm_int64_alu.sv
